### hw/rtl/bfsa_pkg.sv
// shared constants, codes and controller/datapath types for the slot allocator
`timescale 1ns / 1ps

package bfsa_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int SLOT_W     = 8;
    localparam int CNT_W      = 9;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_NORUN  = 2'd2;

    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_START = 2'd1,
        SEL_BEST  = 2'd2
    } t_slot_sel;

    typedef struct packed {
        logic       load;
        logic       rd_start;
        logic       note_old;
        logic       grow_begin;
        logic       grow_step;
        logic       scan_begin;
        logic       scan_step;
        logic       wr_new;
        logic       wr_resize;
        logic       wr_free;
        logic       res_set;
        logic [1:0] res_status;
        t_slot_sel  res_slot;
        logic       res_moved;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       live;
        logic       count_zero;
        logic       shrink;
        logic       pre_fail;
        logic       scan_fin;
        logic       found;
        logic       grow_ok;
        logic       grow_blocked;
        logic       out_free;
    } t_dp_sts;

endpackage

### hw/rtl/bfsa_if.sv
// handshake channels of the slot allocator: request, response and configuration
`timescale 1ns / 1ps

interface bfsa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] start_slot;
    logic [8:0] slot_count;

    modport source (output valid, command, start_slot, slot_count, input ready);
    modport sink   (input valid, command, start_slot, slot_count, output ready);
endinterface

interface bfsa_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] result_slot;
    logic       moved;
    logic [8:0] slots_in_use;
    logic [8:0] peak_in_use;

    modport source (output valid, status, result_slot, moved, slots_in_use, peak_in_use,
                    input ready);
    modport sink   (input valid, status, result_slot, moved, slots_in_use, peak_in_use,
                    output ready);
endinterface

interface bfsa_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] pool_slots;

    modport source (output valid, pool_slots, input ready);
    modport sink   (input valid, pool_slots, output ready);
endinterface

### hw/rtl/best_fit_slot_allocator.sv
// top level of the best-fit slot allocator
`timescale 1ns / 1ps

// Hands out contiguous runs from a pool of up to 256 slots, one request word at a time.
// Allocate walks the run-length table from slot 0 with one table read per cycle: each free
// slot takes one read and each live run is skipped with a single read, and the scan stops
// early on an exact fit. Free and a shrinking resize need no scan; a growing resize first
// probes the slots after the run, one per cycle, and falls back to a full allocate scan
// when they are taken or lie past the pool limit. The table has a single read port. The
// pool is empty right after reset and after every pool_slots write, with no clearing pass.
// The response sits in an output register, so a response may wait for the sink while the
// next request is taken.
module best_fit_slot_allocator import bfsa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfsa_in_if.sink    i_cmd,
    bfsa_cfg_if.sink   i_cfg,
    bfsa_out_if.source o_rsp
);

    t_dp_cmd w_ctl;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_cmd.ready = w_in_ready;

    bfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_ctl)
    );

    bfsa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_command    (i_cmd.command),
        .i_start_slot (i_cmd.start_slot),
        .i_slot_count (i_cmd.slot_count),
        .i_cfg        (i_cfg),
        .o_rsp        (o_rsp)
    );

endmodule

### hw/rtl/bfsa_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module bfsa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bfsa_ctrl.sv
// sequencing state machine of the slot allocator
`timescale 1ns / 1ps

module bfsa_ctrl import bfsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_LOOK    = 11'b000_0000_0010,
        S_CHECK   = 11'b000_0000_0100,
        S_DECIDE  = 11'b000_0000_1000,
        S_GROW    = 11'b000_0001_0000,
        S_PRECHK  = 11'b000_0010_0000,
        S_SCAN    = 11'b000_0100_0000,
        S_PICK    = 11'b000_1000_0000,
        S_RELEASE = 11'b001_0000_0000,
        S_DONE    = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                case (i_sts.cmd)
                    CMD_ALLOC: begin
                        n_state = S_PRECHK;
                    end
                    CMD_FREE, CMD_RESIZE: begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_CHECK;
                    end
                    default: begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_NORUN;
                        o_cmd.res_slot   = SEL_ZERO;
                        n_state          = S_DONE;
                    end
                endcase
            end
            S_CHECK: begin
                o_cmd.note_old = 1'b1;
                n_state        = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.res_set = 1'b1;
                n_state       = S_DONE;
                if (!i_sts.live) begin
                    o_cmd.res_status = ST_NORUN;
                    o_cmd.res_slot   = SEL_ZERO;
                end else if (i_sts.cmd == CMD_FREE) begin
                    o_cmd.wr_free    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_slot   = SEL_START;
                end else if (i_sts.count_zero) begin
                    o_cmd.res_status = ST_NOROOM;
                    o_cmd.res_slot   = SEL_ZERO;
                end else if (i_sts.shrink) begin
                    o_cmd.wr_resize  = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_slot   = SEL_START;
                end else begin
                    o_cmd.res_set    = 1'b0;
                    o_cmd.grow_begin = 1'b1;
                    n_state          = S_GROW;
                end
            end
            S_GROW: begin
                if (i_sts.grow_ok) begin
                    o_cmd.wr_resize  = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_slot   = SEL_START;
                    n_state          = S_DONE;
                end else if (i_sts.grow_blocked) begin
                    n_state = S_PRECHK;
                end else begin
                    o_cmd.grow_step = 1'b1;
                end
            end
            S_PRECHK: begin
                if (i_sts.pre_fail) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_NOROOM;
                    o_cmd.res_slot   = SEL_ZERO;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.scan_begin = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_fin) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!i_sts.found) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_NOROOM;
                    o_cmd.res_slot   = SEL_ZERO;
                    n_state          = S_DONE;
                end else if (i_sts.cmd == CMD_RESIZE) begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_RELEASE;
                end else begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_slot   = SEL_BEST;
                    n_state          = S_DONE;
                end
            end
            S_RELEASE: begin
                o_cmd.wr_free    = 1'b1;
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_slot   = SEL_BEST;
                o_cmd.res_moved  = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while an item is in progress");
`endif

endmodule

### hw/rtl/bfsa_dp.sv
// datapath of the slot allocator: count table, scan position, totals, result register
`timescale 1ns / 1ps

module bfsa_dp import bfsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_ctl,
    output t_dp_sts           o_sts,
    input  logic [1:0]        i_command,
    input  logic [SLOT_W-1:0] i_start_slot,
    input  logic [CNT_W-1:0]  i_slot_count,
    bfsa_cfg_if.sink          i_cfg,
    bfsa_out_if.source        o_rsp
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

    logic [CNT_W-1:0]      r_pool_slots;
    logic [POOL_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]      r_in_use;
    logic [CNT_W-1:0]      r_peak;
    logic                  r_out_valid;

    logic [1:0]            r_command;
    logic [SLOT_W-1:0]     r_start;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_old;
    logic [CNT_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_run_at;
    logic [CNT_W-1:0]      r_len;
    logic [SLOT_W-1:0]     r_best_at;
    logic [CNT_W-1:0]      r_best_len;
    logic                  r_found;
    logic                  r_rd_vld;
    logic [1:0]            r_res_status;
    logic [SLOT_W-1:0]     r_res_slot;
    logic                  r_res_moved;
    logic [1:0]            r_out_status;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_moved;
    logic [CNT_W-1:0]      r_out_in_use;
    logic [CNT_W-1:0]      r_out_peak;

    logic [CNT_W-1:0]      w_lim;
    logic [CNT_W-1:0]      w_spare;
    logic [CNT_W-1:0]      w_ram_q;
    logic [CNT_W-1:0]      w_rd_d;
    logic [CNT_W:0]        w_target;
    logic [CNT_W-1:0]      w_grow_pos;
    logic [CNT_W-1:0]      w_pos_next;
    logic [CNT_W-1:0]      w_pos_jump;
    logic                  w_rd_en;
    logic [CNT_W-1:0]      w_rd_addr;
    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [CNT_W-1:0]      w_wdata;
    logic [CNT_W-1:0]      n_in_use;
    logic                  w_scan_end;
    logic                  w_boundary;
    logic                  w_fits;
    logic                  w_exact;
    logic                  w_cfg_wr;
    logic                  w_out_free;

    assign w_lim      = (r_pool_slots > DEPTH_CNT) ? DEPTH_CNT : r_pool_slots;
    assign w_spare    = (w_lim > r_in_use) ? (w_lim - r_in_use) : '0;
    assign w_rd_d     = r_rd_vld ? w_ram_q : '0;
    assign w_target   = {2'b00, r_start} + {1'b0, r_count};
    assign w_grow_pos = {1'b0, r_start} + r_old;
    assign w_pos_next = r_pos + CNT_W'(1);
    assign w_pos_jump = r_pos + w_rd_d;

    // scan: a free slot extends the current hole, a live entry closes it and jumps
    assign w_scan_end = r_pos >= w_lim;
    assign w_boundary = w_scan_end || (w_rd_d != '0);
    assign w_fits     = w_boundary && (r_len >= r_count) && (!r_found || (r_len < r_best_len));
    assign w_exact    = w_fits && (r_len == r_count);

    assign w_cfg_wr   = i_cfg.valid && i_cfg.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (i_ctl.rd_start) begin
            w_rd_en   = 1'b1;
            w_rd_addr = {1'b0, r_start};
        end else if (i_ctl.grow_begin) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_grow_pos;
        end else if (i_ctl.grow_step) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_pos_next;
        end else if (i_ctl.scan_begin) begin
            w_rd_en   = 1'b1;
            w_rd_addr = '0;
        end else if (i_ctl.scan_step) begin
            w_rd_en   = 1'b1;
            w_rd_addr = (w_rd_d == '0) ? w_pos_next : w_pos_jump;
        end
    end

    always_comb begin
        w_we     = i_ctl.wr_new || i_ctl.wr_resize || i_ctl.wr_free;
        w_waddr  = i_ctl.wr_new ? r_best_at : r_start;
        w_wdata  = (i_ctl.wr_new || i_ctl.wr_resize) ? r_count : '0;
        n_in_use = r_in_use;
        if (i_ctl.wr_new) begin
            n_in_use = r_in_use + r_count;
        end else if (i_ctl.wr_resize) begin
            n_in_use = r_in_use + r_count - r_old;
        end else if (i_ctl.wr_free) begin
            n_in_use = r_in_use - r_old;
        end
    end

    bfsa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (POOL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr[ADDR_W-1:0]),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_slots <= DEPTH_CNT;
            r_valid      <= '0;
            r_in_use     <= '0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_pool_slots <= i_cfg.pool_slots;
                r_valid      <= '0;
                r_in_use     <= '0;
                r_peak       <= '0;
            end else if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
                r_in_use         <= n_in_use;
                if (n_in_use > r_peak) begin
                    r_peak <= n_in_use;
                end
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_command <= i_command;
            r_start   <= i_start_slot;
            r_count   <= i_slot_count;
        end
        if (w_rd_en) begin
            r_rd_vld <= r_valid[w_rd_addr[ADDR_W-1:0]];
        end
        if (i_ctl.note_old) begin
            r_old <= w_rd_d;
        end
        if (i_ctl.grow_begin) begin
            r_pos <= w_grow_pos;
        end else if (i_ctl.grow_step) begin
            r_pos <= w_pos_next;
        end else if (i_ctl.scan_begin) begin
            r_pos    <= '0;
            r_run_at <= '0;
            r_len    <= '0;
            r_found  <= 1'b0;
        end else if (i_ctl.scan_step) begin
            if (w_fits) begin
                r_best_at  <= r_run_at[SLOT_W-1:0];
                r_best_len <= r_len;
                r_found    <= 1'b1;
            end
            if (!w_scan_end) begin
                if (w_rd_d == '0) begin
                    r_pos <= w_pos_next;
                    r_len <= r_len + CNT_W'(1);
                end else begin
                    r_pos    <= w_pos_jump;
                    r_run_at <= w_pos_jump;
                    r_len    <= '0;
                end
            end
        end
        if (i_ctl.res_set) begin
            r_res_status <= i_ctl.res_status;
            r_res_moved  <= i_ctl.res_moved;
            case (i_ctl.res_slot)
                SEL_START: r_res_slot <= r_start;
                SEL_BEST:  r_res_slot <= r_best_at;
                default:   r_res_slot <= '0;
            endcase
        end
        if (i_ctl.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_moved  <= r_res_moved;
            r_out_in_use <= r_in_use;
            r_out_peak   <= r_peak;
        end
    end

    always_comb begin
        o_sts.cmd          = r_command;
        o_sts.live         = ({1'b0, r_start} < w_lim) && (r_old != '0);
        o_sts.count_zero   = (r_count == '0);
        o_sts.shrink       = (r_count <= r_old);
        o_sts.pre_fail     = (r_count == '0) || (r_count > w_spare);
        o_sts.scan_fin     = w_scan_end || w_exact;
        o_sts.found        = r_found;
        o_sts.grow_ok      = ({1'b0, r_pos} == w_target);
        o_sts.grow_blocked = (r_pos >= w_lim) || (w_rd_d != '0);
        o_sts.out_free     = w_out_free;
    end

    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.result_slot = r_out_slot;
    assign o_rsp.moved       = r_out_moved;
    assign o_rsp.slots_in_use = r_out_in_use;
    assign o_rsp.peak_in_use = r_out_peak;

`ifndef SYNTHESIS
    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_in_use)
        else $error("peak below slots in use");

    a_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= w_lim)
        else $error("slots in use beyond pool limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !i_ctl.out_load)
        else $error("pending response word overwritten");
`endif

endmodule
